// ===== rtl/mcme_pkg.sv =====
// Package for the MIDI control message encoder.
// Holds the mode and status codes, register indexes, the controller state type,
// the command and status structs and the message record. It depends on nothing.
package mcme_pkg;

	localparam int VOICE_COUNT_DEF = 128;

	localparam int CFG_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_ON_PATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_EN = 2'd2;

	localparam logic [3:0] MODE_CC = 4'd1;
	localparam logic [3:0] MODE_RPN = 4'd2;
	localparam logic [3:0] MODE_NRPN = 4'd3;
	localparam logic [3:0] MODE_POLYAT = 4'd4;
	localparam logic [3:0] MODE_CHANPRESS = 4'd5;
	localparam logic [3:0] MODE_BEND = 4'd6;
	localparam logic [3:0] MODE_VELON = 4'd7;
	localparam logic [3:0] MODE_VELOFF = 4'd8;
	localparam logic [3:0] MODE_PITCH = 4'd9;
	localparam logic [3:0] MODE_GATE = 4'd10;

	localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
	localparam logic [3:0] STAT_NOTE_ON = 4'h9;
	localparam logic [3:0] STAT_POLYAT = 4'hA;
	localparam logic [3:0] STAT_CC = 4'hB;
	localparam logic [3:0] STAT_CHANPRESS = 4'hD;
	localparam logic [3:0] STAT_BEND = 4'hE;

	localparam logic [6:0] CC_NRPN_MSB = 7'd99;
	localparam logic [6:0] CC_NRPN_LSB = 7'd98;
	localparam logic [6:0] CC_RPN_MSB = 7'd101;
	localparam logic [6:0] CC_RPN_LSB = 7'd100;
	localparam logic [6:0] CC_DATA_MSB = 7'd6;
	localparam logic [6:0] CC_DATA_LSB = 7'd38;

	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam logic [6:0] VEL_RESET_Q = 7'd64;
	localparam int MAX_MSGS = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUANT,
		ST_BUILD,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic capture;
		logic quant;
		logic build;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic has_msgs;
		logic last_msg;
	} stat_t;

	typedef struct packed {
		logic [3:0] hi;
		logic [6:0] d1;
		logic [6:0] d2;
	} msg_t;

	typedef struct packed {
		logic pitch_we;
		logic von_we;
		logic voff_we;
		logic [6:0] addr;
		logic [6:0] data;
	} tbl_wr_t;

	function automatic msg_t mk_msg(logic [3:0] hi, logic [6:0] d1, logic [6:0] d2);
		msg_t m;
		m.hi = hi;
		m.d1 = d1;
		m.d2 = d2;
		return m;
	endfunction

	function automatic logic [6:0] cc_low_id(logic [6:0] cid);
		logic [6:0] r;
		r = 7'd0;
		if (cid == CC_NRPN_MSB) r = CC_NRPN_LSB;
		if (cid == CC_RPN_MSB) r = CC_RPN_LSB;
		if (cid == CC_DATA_MSB) r = CC_DATA_LSB;
		return r;
	endfunction

endpackage

// ===== rtl/mcme_tables.sv =====
// Per-voice note table and per-note velocity tables of the encoder.
// Entries hold quantized values; valid bits give the reset contents.
// Depends on mcme_pkg.
module mcme_tables #(
	parameter int VOICE_COUNT = mcme_pkg::VOICE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pitch_rd,
	input  logic [6:0]      pitch_rd_voice,
	output logic [6:0]      note,
	input  logic            vel_rd,
	input  logic [6:0]      vel_rd_note,
	output logic [6:0]      vel_on,
	output logic [6:0]      vel_off,
	input  mcme_pkg::tbl_wr_t wr
);
	import mcme_pkg::*;

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	logic [6:0] pitch_mem [VOICE_COUNT];
	logic [6:0] von_mem [128];
	logic [6:0] voff_mem [128];
	logic [VOICE_COUNT-1:0] pvalid_q;
	logic [127:0] vonvalid_q;
	logic [127:0] voffvalid_q;

	logic [6:0] pdata_q;
	logic [6:0] paddr_q;
	logic       pv_q;
	logic [6:0] von_data_q;
	logic [6:0] voff_data_q;
	logic       vonv_q;
	logic       voffv_q;

	logic [VIDX_W-1:0] p_ra;
	logic [VIDX_W-1:0] p_wa;

	assign p_ra = pitch_rd_voice[VIDX_W-1:0];
	assign p_wa = wr.addr[VIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
			vonvalid_q <= '0;
			voffvalid_q <= '0;
		end else begin
			if (wr.pitch_we) pvalid_q[p_wa] <= 1'b1;
			if (wr.von_we) vonvalid_q[wr.addr] <= 1'b1;
			if (wr.voff_we) voffvalid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.pitch_we) pitch_mem[p_wa] <= wr.data;
		if (wr.von_we) von_mem[wr.addr] <= wr.data;
		if (wr.voff_we) voff_mem[wr.addr] <= wr.data;
		if (pitch_rd) begin
			pdata_q <= pitch_mem[p_ra];
			pv_q <= pvalid_q[p_ra];
			paddr_q <= pitch_rd_voice;
		end
		if (vel_rd) begin
			von_data_q <= von_mem[vel_rd_note];
			voff_data_q <= voff_mem[vel_rd_note];
			vonv_q <= vonvalid_q[vel_rd_note];
			voffv_q <= voffvalid_q[vel_rd_note];
		end
	end

	// An unwritten note entry maps voice i to note i; velocities start at half scale.
	assign note = pv_q ? pdata_q : paddr_q;
	assign vel_on = vonv_q ? von_data_q : VEL_RESET_Q;
	assign vel_off = voffv_q ? voff_data_q : VEL_RESET_Q;

endmodule

// ===== rtl/mcme_ctrl.sv =====
// Controller state machine of the encoder: sequences capture, quantization,
// message building and serial delivery. Depends on mcme_pkg.
module mcme_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mcme_pkg::cmd_t  cmd,
	input  mcme_pkg::stat_t stat
);
	import mcme_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_QUANT;
				end
			end
			ST_QUANT: begin
				cmd.quant = 1'b1;
				state_d = ST_BUILD;
			end
			ST_BUILD: begin
				cmd.build = 1'b1;
				state_d = stat.has_msgs ? ST_SEND : ST_IDLE;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.advance = 1'b1;
					if (stat.last_msg) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/mcme_dp.sv =====
// Datapath of the encoder: configuration registers, item capture, quantizers,
// message builder, send state and the outgoing message buffer.
// Depends on mcme_pkg; works with mcme_tables through read and write ports.
module mcme_dp #(
	parameter int VOICE_COUNT = mcme_pkg::VOICE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcme_pkg::cmd_t                 cmd,
	output mcme_pkg::stat_t                stat,
	input  logic                           cfg_write,
	input  logic [mcme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcme_pkg::CFG_W-1:0]     cfg_data,
	input  logic [3:0]                     mode,
	input  logic [13:0]                    param_number,
	input  logic [15:0]                    level,
	input  logic [6:0]                     voice,
	input  logic                           patch_change,
	input  logic [31:0]                    timestamp,
	input  logic signed [14:0]             last_sent,
	input  logic [6:0]                     note,
	input  logic [6:0]                     vel_on,
	input  logic [6:0]                     vel_off,
	output logic [6:0]                     vel_rd_note,
	output mcme_pkg::tbl_wr_t              tbl_wr,
	output logic [7:0]                     status_byte,
	output logic [6:0]                     data_one,
	output logic [6:0]                     data_two,
	output logic signed [14:0]             new_last_sent,
	output logic                           last_of_run
);
	import mcme_pkg::*;

	logic [3:0]  channel_q;
	logic        sopc_q;
	logic        out_en_q;

	logic [3:0]  mode_q;
	logic [13:0] pnum_q;
	logic [15:0] lvl_q;
	logic [6:0]  voice_q;
	logic        drop_q;
	logic [31:0] ts_q;
	logic [14:0] last_q;

	logic [6:0]  q127_q;
	logic [13:0] q16_q;

	logic [31:0] lst_time_q;
	logic [15:0] hdr_q;

	msg_t        msg_q [MAX_MSGS];
	logic [2:0]  cnt_q;
	logic [1:0]  idx_q;
	logic [14:0] newlast_q;

	logic [22:0] p127;
	logic [29:0] p16;

	msg_t        m [MAX_MSGS];
	logic [2:0]  n;
	logic [14:0] nl;
	logic        upd_time;
	logic        set_hdr;
	logic [15:0] key;
	logic        late;
	logic        chg;
	logic        gate_on;
	logic [6:0]  cid;
	logic [6:0]  low_id;
	logic [13:0] q_cc;
	logic [14:0] q_gate;
	tbl_wr_t     wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
			sopc_q <= 1'b0;
			out_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CHANNEL: channel_q <= cfg_data;
				REG_SEND_ON_PATCH: sopc_q <= cfg_data[0];
				REG_OUTPUT_EN: out_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			pnum_q <= param_number;
			lvl_q <= (level > ONE_Q15) ? ONE_Q15 : level;
			voice_q <= voice;
			ts_q <= timestamp;
			last_q <= last_sent;
			drop_q <= (!sopc_q && patch_change) ||
				((mode >= MODE_POLYAT) && ({1'b0, voice} >= 8'(VOICE_COUNT)));
		end
		if (cmd.quant) begin
			q127_q <= p127[21:15];
			q16_q <= p16[28:15];
		end
	end

	assign p127 = 23'(lvl_q) * 23'd127 + 23'd16384;
	assign p16 = 30'(lvl_q) * 30'd16383 + 30'd16384;

	assign vel_rd_note = note;

	always_comb begin
		for (int i = 0; i < MAX_MSGS; i++) m[i] = '0;
		n = '0;
		nl = last_q;
		upd_time = 1'b0;
		set_hdr = 1'b0;
		key = {1'b1, (mode_q == MODE_NRPN), pnum_q};
		late = lst_time_q > ts_q;
		chg = 1'b0;
		gate_on = lvl_q != '0;
		cid = (mode_q == MODE_NRPN) ? CC_NRPN_MSB : CC_RPN_MSB;
		low_id = cc_low_id(pnum_q[6:0]);
		q_cc = {q127_q, 7'd0};
		q_gate = {8'd0, {7{gate_on}}};
		wr = '0;
		wr.addr = voice_q;
		wr.data = q127_q;
		if (!drop_q) begin
			unique case (mode_q) inside
				MODE_CC, MODE_RPN, MODE_NRPN: begin
					if (out_en_q && !late) begin
						upd_time = 1'b1;
						if (mode_q == MODE_CC) begin
							if ({1'b0, q_cc} != last_q) begin
								nl = {1'b0, q_cc};
								m[0] = mk_msg(STAT_CC, pnum_q[6:0], q127_q);
								n = 3'd1;
								if (low_id != 7'd0) begin
									m[1] = mk_msg(STAT_CC, low_id, 7'd0);
									n = 3'd2;
								end
							end
						end else begin
							chg = {1'b0, q16_q} != last_q;
							if (chg) nl = {1'b0, q16_q};
							if (hdr_q != key) begin
								set_hdr = 1'b1;
								m[0] = mk_msg(STAT_CC, cid, pnum_q[13:7]);
								m[1] = mk_msg(STAT_CC, cc_low_id(cid), pnum_q[6:0]);
								n = 3'd2;
							end
							if (chg) begin
								m[n[1:0]] = mk_msg(STAT_CC, CC_DATA_MSB, q16_q[13:7]);
								m[n[1:0] + 2'd1] = mk_msg(STAT_CC, CC_DATA_LSB, q16_q[6:0]);
								n = n + 3'd2;
							end
						end
					end
				end
				MODE_POLYAT, MODE_CHANPRESS: begin
					if ({8'd0, q127_q} != last_q) begin
						nl = {8'd0, q127_q};
						upd_time = 1'b1;
						m[0] = (mode_q == MODE_POLYAT) ?
							mk_msg(STAT_POLYAT, voice_q, q127_q) :
							mk_msg(STAT_CHANPRESS, q127_q, 7'd0);
						n = 3'd1;
					end
				end
				MODE_BEND: begin
					if ({1'b0, q16_q} != last_q) begin
						nl = {1'b0, q16_q};
						upd_time = 1'b1;
						m[0] = mk_msg(STAT_BEND, q16_q[6:0], q16_q[13:7]);
						n = 3'd1;
					end
				end
				MODE_VELON: wr.von_we = 1'b1;
				MODE_VELOFF: wr.voff_we = 1'b1;
				MODE_PITCH: wr.pitch_we = 1'b1;
				MODE_GATE: begin
					if (q_gate != last_q) begin
						nl = q_gate;
						upd_time = 1'b1;
						m[0] = gate_on ? mk_msg(STAT_NOTE_ON, note, vel_on) :
							mk_msg(STAT_NOTE_OFF, note, vel_off);
						n = 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		tbl_wr = wr;
		tbl_wr.pitch_we = wr.pitch_we && cmd.build;
		tbl_wr.von_we = wr.von_we && cmd.build;
		tbl_wr.voff_we = wr.voff_we && cmd.build;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lst_time_q <= '0;
			hdr_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.build) begin
				cnt_q <= n;
				idx_q <= '0;
				if (upd_time) lst_time_q <= ts_q;
				if (set_hdr) hdr_q <= key;
			end else if (cmd.advance) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			msg_q <= m;
			newlast_q <= nl;
		end
	end

	assign stat.has_msgs = n != 3'd0;
	assign stat.last_msg = last_of_run;

	assign status_byte = {msg_q[idx_q].hi, channel_q};
	assign data_one = msg_q[idx_q].d1;
	assign data_two = msg_q[idx_q].d2;
	assign new_last_sent = newlast_q;
	assign last_of_run = ({1'b0, idx_q} + 3'd1) == cnt_q;

endmodule

// ===== rtl/midi_control_message_encoder.sv =====
// Top level of the MIDI control message encoder.
// Ties together mcme_ctrl, mcme_dp and mcme_tables; depends on mcme_pkg.
//
// Usage: an item arrives on the in_valid/in_ready channel and yields zero to
// four three-byte MIDI messages on the out_valid/out_ready channel, one
// transaction per message, with last_of_run marking the final one.
// The block works on one item at a time. After an input transaction it
// steps through capture with note table read, quantization with velocity
// table read and message build before the first message is offered; further
// messages follow one per cycle while the receiver is ready. An item that
// only writes a table or sends nothing returns to idle after the build;
// in_ready rises again the cycle after the last message is taken. The two
// table reads in series set the lead. A receiver stall holds the current
// message steady and stops the block. Reset clears the state, send time and
// stored RPN/NRPN header and restores the configuration; the tables return
// to their initial contents at once via valid bits. Configuration writes
// are registered; the user makes them only while idle (not enforced).
module midi_control_message_encoder #(
	parameter int VOICE_COUNT = mcme_pkg::VOICE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mcme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcme_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3:0]                     mode,
	input  logic [13:0]                    param_number,
	input  logic [15:0]                    level,
	input  logic [6:0]                     voice,
	input  logic                           patch_change,
	input  logic [31:0]                    timestamp,
	input  logic signed [14:0]             last_sent,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     status_byte,
	output logic [6:0]                     data_one,
	output logic [6:0]                     data_two,
	output logic signed [14:0]             new_last_sent,
	output logic                           last_of_run
);
	import mcme_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	tbl_wr_t tbl_wr;
	logic [6:0] note;
	logic [6:0] vel_on;
	logic [6:0] vel_off;
	logic [6:0] vel_rd_note;

	mcme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mcme_tables #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_tables (
		.clk            (clk),
		.arst_n         (arst_n),
		.pitch_rd       (cmd.capture),
		.pitch_rd_voice (voice),
		.note           (note),
		.vel_rd         (cmd.quant),
		.vel_rd_note    (vel_rd_note),
		.vel_on         (vel_on),
		.vel_off        (vel_off),
		.wr             (tbl_wr)
	);

	mcme_dp #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.param_number  (param_number),
		.level         (level),
		.voice         (voice),
		.patch_change  (patch_change),
		.timestamp     (timestamp),
		.last_sent     (last_sent),
		.note          (note),
		.vel_on        (vel_on),
		.vel_off       (vel_off),
		.vel_rd_note   (vel_rd_note),
		.tbl_wr        (tbl_wr),
		.status_byte   (status_byte),
		.data_one      (data_one),
		.data_two      (data_two),
		.new_last_sent (new_last_sent),
		.last_of_run   (last_of_run)
	);

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input accepted while messages are pending");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("message offered in the cycle after an input transaction");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> out_valid)
		else $error("run of messages ended before its last message");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run) |=> (in_ready && !out_valid))
		else $error("block not idle after the last message of a run");

endmodule

// ===== bench/midi_control_message_encoder_test.sv =====
// Self-checking bench for the MIDI control message encoder, built on mcme_pkg.
// A tracker class predicts the messages of every accepted transaction and checks
// each message taken from the output channel against the oldest prediction.
`timescale 1ns / 100ps

module midi_control_message_encoder_test;
	import mcme_pkg::*;

	localparam logic [3:0] MODE_IDLE = 4'd0;
	localparam logic [3:0] MODE_SPARE_LO = 4'd11;
	localparam logic [3:0] MODE_SPARE_HI = 4'd15;

	typedef struct {
		logic [3:0]         mode;
		logic [13:0]        param;
		logic [15:0]        level;
		logic [6:0]         voice;
		logic               patch;
		logic [31:0]        stamp;
		logic signed [14:0] last;
	} control_item_t;

	typedef struct {
		logic [7:0]  status;
		logic [6:0]  data_one;
		logic [6:0]  data_two;
		logic [14:0] new_last;
		logic        last;
	} midi_msg_t;

	class midi_message_tracker;
		logic [3:0]  channel;
		logic        patch_ok;
		logic        cc_enabled;
		logic [31:0] send_time;
		logic [15:0] header_key;
		logic [15:0] pitch_notes[128];
		logic [15:0] vel_on[128];
		logic [15:0] vel_off[128];
		logic [14:0] carried;
		midi_msg_t   staged[$];
		midi_msg_t   pending_msgs[$];
		int          failures;

		function new();
			channel = 4'd0;
			patch_ok = 1'b0;
			cc_enabled = 1'b1;
			send_time = 32'd0;
			header_key = 16'd0;
			failures = 0;
			for (int i = 0; i < 128; i++) begin
				pitch_notes[i] = 16'((i * 65536 + 127) / 254);
				vel_on[i] = 16'd16384;
				vel_off[i] = 16'd16384;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_CHANNEL: channel = val;
				REG_SEND_ON_PATCH: patch_ok = val[0];
				REG_OUTPUT_EN: cc_enabled = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned scale(int unsigned lvl, int unsigned steps);
			return (lvl * steps + 16384) >> 15;
		endfunction

		function int unsigned clip(logic [15:0] v);
			return (v > ONE_Q15) ? 32'(ONE_Q15) : 32'(v);
		endfunction

		// Quantised value that a transaction would send, compared with last_sent.
		function int code_for(control_item_t it);
			int unsigned lvl;
			lvl = clip(it.level);
			case (it.mode)
				MODE_CC: return scale(lvl, 127) << 7;
				MODE_RPN, MODE_NRPN, MODE_BEND: return scale(lvl, 16383);
				MODE_POLYAT, MODE_CHANPRESS: return scale(lvl, 127);
				MODE_GATE: return (lvl > 0) ? 127 : 0;
				default: return 0;
			endcase
		endfunction

		function void add_msg(logic [3:0] hi, int unsigned d1, int unsigned d2);
			midi_msg_t m;
			m.status = {hi, channel};
			m.data_one = d1[6:0];
			m.data_two = d2[6:0];
			m.new_last = carried;
			m.last = 1'b0;
			staged.push_back(m);
		endfunction

		function void add_controller(logic [6:0] cid, int unsigned val);
			logic [6:0] low_id;
			low_id = 7'd0;
			if (cid == CC_NRPN_MSB) low_id = CC_NRPN_LSB;
			else if (cid == CC_RPN_MSB) low_id = CC_RPN_LSB;
			else if (cid == CC_DATA_MSB) low_id = CC_DATA_LSB;
			add_msg(STAT_CC, cid, val >> 7);
			if (low_id != 7'd0) add_msg(STAT_CC, low_id, val);
		endfunction

		function void note_item(control_item_t it);
			int unsigned lvl;
			int unsigned note;
			int unsigned vel;
			int          prior;
			int          q;
			logic [15:0] key;
			staged.delete();
			lvl = clip(it.level);
			prior = it.last;
			q = code_for(it);
			carried = it.last;
			if (it.patch && !patch_ok) return;
			if (it.mode >= MODE_POLYAT && it.voice >= VOICE_COUNT_DEF) return;
			case (it.mode)
				MODE_CC, MODE_RPN, MODE_NRPN: begin
					if (cc_enabled && send_time <= it.stamp) begin
						send_time = it.stamp;
						if (q != prior) carried = q[14:0];
						if (it.mode == MODE_CC) begin
							if (q != prior) add_controller(it.param[6:0], q);
						end else begin
							key = {1'b1, it.mode == MODE_NRPN, it.param};
							if (header_key != key) begin
								add_controller((it.mode == MODE_NRPN) ? CC_NRPN_MSB : CC_RPN_MSB,
									it.param);
								header_key = key;
							end
							if (q != prior) add_controller(CC_DATA_MSB, q);
						end
					end
				end
				MODE_POLYAT, MODE_CHANPRESS, MODE_BEND: begin
					if (q != prior) begin
						carried = q[14:0];
						send_time = it.stamp;
						if (it.mode == MODE_POLYAT) add_msg(STAT_POLYAT, it.voice, q);
						else if (it.mode == MODE_CHANPRESS) add_msg(STAT_CHANPRESS, q, 0);
						else add_msg(STAT_BEND, q, q >> 7);
					end
				end
				MODE_VELON: vel_on[it.voice] = lvl[15:0];
				MODE_VELOFF: vel_off[it.voice] = lvl[15:0];
				MODE_PITCH: pitch_notes[it.voice] = lvl[15:0];
				MODE_GATE: begin
					// The velocity tables are looked up by note number, not by voice.
					note = scale(clip(pitch_notes[it.voice]), 127) & 127;
					if (q != prior) begin
						carried = q[14:0];
						vel = scale(clip((lvl > 0) ? vel_on[note] : vel_off[note]), 127);
						send_time = it.stamp;
						add_msg((lvl > 0) ? STAT_NOTE_ON : STAT_NOTE_OFF, note, vel);
					end
				end
				default: ;
			endcase
			if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
			foreach (staged[i]) pending_msgs.push_back(staged[i]);
		endfunction

		function void compare(string field, int unsigned want_v, int unsigned seen_v);
			if (want_v != seen_v) begin
				$error("%s: expected %0h, got %0h", field, want_v, seen_v);
				failures++;
			end
		endfunction

		function void check_message(midi_msg_t seen);
			midi_msg_t want;
			if (pending_msgs.size() == 0) begin
				$error("status_byte: expected no message, got %0h", seen.status);
				failures++;
				return;
			end
			want = pending_msgs.pop_front();
			compare("status_byte", want.status, seen.status);
			compare("data_one", want.data_one, seen.data_one);
			compare("data_two", want.data_two, seen.data_two);
			compare("new_last_sent", want.new_last, seen.new_last);
			compare("last_of_run", want.last, seen.last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [3:0]            mode;
	logic [13:0]           param_number;
	logic [15:0]           level;
	logic [6:0]            voice;
	logic                  patch_change;
	logic [31:0]           timestamp;
	logic signed [14:0]    last_sent;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            status_byte;
	logic [6:0]            data_one;
	logic [6:0]            data_two;
	logic signed [14:0]    new_last_sent;
	logic                  last_of_run;

	midi_message_tracker tracker = new();
	int                  idle_pct = 38;
	logic                patch_now = 1'b0;
	logic [31:0]         stamp_now = 32'd30;

	midi_control_message_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.param_number  (param_number),
		.level         (level),
		.voice         (voice),
		.patch_change  (patch_change),
		.timestamp     (timestamp),
		.last_sent     (last_sent),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status_byte   (status_byte),
		.data_one      (data_one),
		.data_two      (data_two),
		.new_last_sent (new_last_sent),
		.last_of_run   (last_of_run)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		midi_msg_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.status = status_byte;
			seen.data_one = data_one;
			seen.data_two = data_two;
			seen.new_last = new_last_sent;
			seen.last = last_of_run;
			tracker.check_message(seen);
		end
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	task automatic push_item(control_item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		param_number <= it.param;
		level <= it.level;
		voice <= it.voice;
		patch_change <= it.patch;
		timestamp <= it.stamp;
		last_sent <= it.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_item(it);
	endtask

	task automatic direct(logic [3:0] m, logic [13:0] p, logic [15:0] l, logic [6:0] v,
			logic pc, logic [31:0] ts, logic signed [14:0] ls);
		control_item_t it;
		it.mode = m;
		it.param = p;
		it.level = l;
		it.voice = v;
		it.patch = pc;
		it.stamp = ts;
		it.last = ls;
		push_item(it);
	endtask

	// Holds the sender off until every predicted message has been taken and the
	// block has had time to finish any transaction that sends nothing.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_msgs.size() != 0) @(posedge clk);
		while (!in_ready) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_registers(logic [3:0] ch, logic sop, logic oe);
		cfg_write <= 1'b1;
		cfg_index <= REG_CHANNEL;
		cfg_data <= ch;
		@(posedge clk);
		cfg_index <= REG_SEND_ON_PATCH;
		cfg_data <= {3'b000, sop};
		@(posedge clk);
		cfg_index <= REG_OUTPUT_EN;
		cfg_data <= {3'b000, oe};
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.write_register(REG_CHANNEL, ch);
		tracker.write_register(REG_SEND_ON_PATCH, {3'b000, sop});
		tracker.write_register(REG_OUTPUT_EN, {3'b000, oe});
		patch_now = sop;
		@(posedge clk);
	endtask

	function automatic control_item_t random_item();
		control_item_t it;
		int unsigned   pick;
		pick = $urandom_range(0, 99);
		if (pick < 18) it.mode = MODE_CC;
		else if (pick < 30) it.mode = MODE_RPN;
		else if (pick < 42) it.mode = MODE_NRPN;
		else if (pick < 50) it.mode = MODE_POLYAT;
		else if (pick < 56) it.mode = MODE_CHANPRESS;
		else if (pick < 64) it.mode = MODE_BEND;
		else if (pick < 70) it.mode = MODE_VELON;
		else if (pick < 76) it.mode = MODE_VELOFF;
		else if (pick < 82) it.mode = MODE_PITCH;
		else if (pick < 96) it.mode = MODE_GATE;
		else if (pick < 98) it.mode = MODE_IDLE;
		else it.mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));

		case ($urandom_range(0, 9))
			0: it.param = 14'd0;
			1: it.param = {7'd0, CC_DATA_MSB};
			2: it.param = {7'd0, CC_NRPN_MSB};
			3: it.param = {7'd0, CC_RPN_MSB};
			4: it.param = 14'h3fff;
			default: it.param = 14'($urandom());
		endcase

		pick = $urandom_range(0, 19);
		if (pick < 2) it.level = 16'd0;
		else if (pick < 4) it.level = ONE_Q15;
		else if (pick < 5) it.level = 16'($urandom_range(32769, 65535));
		else it.level = 16'($urandom_range(0, 32768));
		// Low pitches keep gate notes on the few velocity entries that get written.
		if (it.mode == MODE_PITCH && $urandom_range(0, 1)) it.level = 16'($urandom_range(0, 800));

		it.voice = $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
		it.patch = ($urandom_range(0, 9) == 0);

		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			it.stamp = $urandom();
		end else if (pick < 3) begin
			it.stamp = stamp_now - $urandom_range(1, 40);
		end else begin
			stamp_now = stamp_now + $urandom_range(0, 30);
			it.stamp = stamp_now;
		end

		pick = $urandom_range(0, 9);
		if (pick < 3) it.last = -15'sd1;
		else if (pick < 7) it.last = 15'(tracker.code_for(it));
		else it.last = 15'($urandom_range(0, 32767));
		return it;
	endfunction

	initial begin
		control_item_t it;
		int            counted;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CHANNEL;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_IDLE;
		param_number = '0;
		level = '0;
		voice = '0;
		patch_change = 1'b0;
		timestamp = '0;
		last_sent = '0;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		direct(MODE_CC, 14'd7, 16'd0, 7'd0, 1'b0, 32'd10, -1);
		direct(MODE_CC, 14'd99, 16'd32768, 7'd0, 1'b0, 32'd11, -1);
		direct(MODE_CC, 14'd6, 16'd16384, 7'd0, 1'b0, 32'd12, 15'sd8192);
		direct(MODE_CC, 14'd101, 16'hffff, 7'd0, 1'b0, 32'd13, -1);
		direct(MODE_RPN, 14'h3fff, 16'd32768, 7'd0, 1'b0, 32'd14, -1);
		direct(MODE_RPN, 14'h3fff, 16'd0, 7'd0, 1'b0, 32'd15, -1);
		direct(MODE_NRPN, 14'd0, 16'd1, 7'd0, 1'b0, 32'd16, 15'sd0);
		direct(MODE_CC, 14'd7, 16'd100, 7'd0, 1'b0, 32'd5, -1);
		direct(MODE_POLYAT, 14'd0, 16'd32768, 7'd127, 1'b0, 32'd3, -1);
		direct(MODE_CHANPRESS, 14'd0, 16'd12345, 7'd0, 1'b0, 32'd4, -1);
		direct(MODE_BEND, 14'd0, 16'd32768, 7'd0, 1'b0, 32'hffffffff, -1);
		direct(MODE_CC, 14'd0, 16'd32768, 7'd0, 1'b0, 32'd100, -1);
		direct(MODE_BEND, 14'd0, 16'd16384, 7'd0, 1'b0, 32'd20, -1);
		direct(MODE_VELON, 14'd0, 16'd40000, 7'd64, 1'b0, 32'd20, -1);
		direct(MODE_VELOFF, 14'd0, 16'd0, 7'd0, 1'b0, 32'd20, -1);
		direct(MODE_PITCH, 14'd0, 16'd32768, 7'd5, 1'b0, 32'd20, -1);
		direct(MODE_GATE, 14'd0, 16'd1, 7'd5, 1'b0, 32'd21, -1);
		direct(MODE_GATE, 14'd0, 16'd32768, 7'd64, 1'b0, 32'd22, -1);
		direct(MODE_GATE, 14'd0, 16'd0, 7'd0, 1'b0, 32'd23, -1);
		direct(MODE_GATE, 14'd0, 16'd0, 7'd0, 1'b0, 32'd24, 15'sd0);
		direct(MODE_IDLE, 14'h3fff, 16'hffff, 7'd127, 1'b0, 32'd25, -1);
		direct(MODE_SPARE_HI, 14'h3fff, 16'd32768, 7'd1, 1'b0, 32'd25, -1);
		direct(MODE_SPARE_LO, 14'd5, 16'd32768, 7'd1, 1'b0, 32'd25, -1);
		direct(MODE_CC, 14'd7, 16'd32768, 7'd0, 1'b1, 32'd26, -1);
		direct(MODE_NRPN, 14'h2aaa, 16'h5555, 7'h2a, 1'b0, 32'd30, 15'sh2aaa);
		settle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: program_registers(4'd15, 1'b1, 1'b1);
				1: program_registers(4'd0, 1'b1, 1'b0);
				2: program_registers(4'($urandom_range(0, 15)), 1'b0, 1'b1);
				3: program_registers(4'($urandom_range(0, 15)), 1'b1, 1'b1);
				default: program_registers(4'd9, 1'b0, 1'b1);
			endcase
			idle_pct = (phase == 2) ? 0 : 38;
			counted = 0;
			while (counted < 30) begin
				it = random_item();
				push_item(it);
				if (it.mode >= MODE_CC && it.mode <= MODE_GATE && (!it.patch || patch_now))
					counted++;
			end
			settle();
		end

		if (tracker.failures == 0 && tracker.pending_msgs.size() == 0)
			$display("midi_control_message_encoder: match");
		else
			$display("midi_control_message_encoder: mismatch");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("midi_control_message_encoder: mismatch");
		$finish;
	end

endmodule
